FILE: sv/bsp_pkg.sv
// bsp_pkg: shared types, codes and constants of the bencode scalar token parser
// no dependencies; used by every module of the block

package bsp_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    localparam int unsigned MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DATA = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HALT = 3'd4;

    localparam logic [1:0] KIND_INT     = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_BAD_LEAD     = 3'd0;
    localparam logic [2:0] ERR_LEADING_ZERO = 3'd1;
    localparam logic [2:0] ERR_MALFORMED    = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG     = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd5;

    localparam logic [7:0] CHAR_I     = 8'h69;
    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [32:0] MAX_LEN_RESET = 33'd134217728;
    localparam logic [67:0] INT_POS_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] INT_NEG_LIMIT = 68'h0_8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] int_value;
        logic [31:0]        string_length;
        logic [7:0]         payload_byte;
        logic               last_of_string;
        logic [2:0]         error_code;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

FILE: sv/bsp_in_reg.sv
// bsp_in_reg: input register holding one request until the parse stage takes it
// depends on bsp_pkg

module bsp_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bsp_pkg::in_item_t in_item,
    input  logic              take,
    output logic              held_valid,
    output bsp_pkg::in_item_t held_item
);

    logic              valid_reg;
    logic              valid_next;
    bsp_pkg::in_item_t item_reg;
    logic              load;

    assign in_stall   = valid_reg & ~take;
    assign load       = in_valid & ~in_stall;
    assign valid_next = load | (valid_reg & ~take);
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: sv/bsp_parse_core.sv
// bsp_parse_core: token state machine, digit accumulate and result generation
// depends on bsp_pkg

module bsp_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  bsp_pkg::in_item_t item,
    input  logic [32:0]       max_len,
    output bsp_pkg::push_t    push
);

    logic [bsp_pkg::MODE_W-1:0] mode_reg;
    logic [bsp_pkg::MODE_W-1:0] mode_next;
    logic                       neg_reg;
    logic                       neg_next;
    logic [63:0]                acc_reg;
    logic [63:0]                acc_next;
    logic                       seen_reg;
    logic                       seen_next;
    logic                       fz_reg;
    logic                       fz_next;
    logic [32:0]                rem_reg;
    logic [32:0]                rem_next;

    always_comb
    begin
        logic              is_digit;
        logic [3:0]        digit;
        logic [63:0]       base;
        logic [67:0]       base_ext;
        logic [67:0]       prod;
        logic [67:0]       limit;
        logic [32:0]       len;
        logic              r0_valid;
        bsp_pkg::result_t  r0;
        bsp_pkg::result_t  r_trunc;
        logic              fail;
        logic [2:0]        fail_code;

        is_digit  = item.data_byte inside {[bsp_pkg::CHAR_ZERO:bsp_pkg::CHAR_NINE]};
        digit     = 4'(item.data_byte - bsp_pkg::CHAR_ZERO);
        base      = (mode_reg == bsp_pkg::MODE_IDLE) ? 64'd0 : acc_reg;
        base_ext  = {4'd0, base};
        prod      = (base_ext << 3) + (base_ext << 1) + {64'd0, digit};
        limit     = neg_reg ? bsp_pkg::INT_NEG_LIMIT : bsp_pkg::INT_POS_LIMIT;
        len       = acc_reg[32:0];
        r0_valid  = 1'b0;
        r0        = '0;
        r_trunc   = '0;
        fail      = 1'b0;
        fail_code = bsp_pkg::ERR_BAD_LEAD;

        mode_next = mode_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        fz_next   = fz_reg;
        rem_next  = rem_reg;

        case (mode_reg)
            bsp_pkg::MODE_IDLE:
            begin
                if (item.data_byte == bsp_pkg::CHAR_I)
                begin
                    neg_next  = 1'b0;
                    acc_next  = 64'd0;
                    seen_next = 1'b0;
                    fz_next   = 1'b0;
                    rem_next  = 33'd0;
                    mode_next = bsp_pkg::MODE_INT;
                end
                else if (is_digit)
                begin
                    neg_next  = 1'b0;
                    seen_next = 1'b0;
                    fz_next   = 1'b0;
                    rem_next  = 33'd0;
                    acc_next  = {60'd0, digit};
                    if (prod >= {35'd0, max_len})
                    begin
                        fail      = 1'b1;
                        fail_code = bsp_pkg::ERR_TOO_LONG;
                    end
                    else
                    begin
                        mode_next = bsp_pkg::MODE_LEN;
                    end
                end
                else if (item.data_byte == bsp_pkg::CHAR_COLON)
                begin
                    fail      = 1'b1;
                    fail_code = bsp_pkg::ERR_MALFORMED;
                end
                else
                begin
                    fail      = 1'b1;
                    fail_code = bsp_pkg::ERR_BAD_LEAD;
                end
            end
            bsp_pkg::MODE_INT:
            begin
                if (item.data_byte == bsp_pkg::CHAR_MINUS)
                begin
                    if (neg_reg || seen_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = bsp_pkg::ERR_MALFORMED;
                    end
                    else
                    begin
                        neg_next = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    if (seen_reg && fz_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = bsp_pkg::ERR_LEADING_ZERO;
                    end
                    else if (prod > limit)
                    begin
                        fail      = 1'b1;
                        fail_code = bsp_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        if (!seen_reg)
                        begin
                            fz_next = (digit == 4'd0);
                        end
                        seen_next = 1'b1;
                        acc_next  = prod[63:0];
                    end
                end
                else if (item.data_byte == bsp_pkg::CHAR_E && seen_reg)
                begin
                    r0_valid     = 1'b1;
                    r0.kind      = bsp_pkg::KIND_INT;
                    r0.int_value = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
                    neg_next     = 1'b0;
                    acc_next     = 64'd0;
                    seen_next    = 1'b0;
                    fz_next      = 1'b0;
                    rem_next     = 33'd0;
                    mode_next    = bsp_pkg::MODE_IDLE;
                end
                else
                begin
                    fail      = 1'b1;
                    fail_code = bsp_pkg::ERR_MALFORMED;
                end
            end
            bsp_pkg::MODE_LEN:
            begin
                if (is_digit)
                begin
                    if (prod >= {35'd0, max_len})
                    begin
                        fail      = 1'b1;
                        fail_code = bsp_pkg::ERR_TOO_LONG;
                    end
                    else
                    begin
                        acc_next = prod[63:0];
                    end
                end
                else if (item.data_byte == bsp_pkg::CHAR_COLON)
                begin
                    r0_valid          = 1'b1;
                    r0.kind           = bsp_pkg::KIND_HEADER;
                    r0.string_length  = len[31:0];
                    r0.last_of_string = (len == 33'd0);
                    neg_next          = 1'b0;
                    acc_next          = 64'd0;
                    seen_next         = 1'b0;
                    fz_next           = 1'b0;
                    if (len == 33'd0)
                    begin
                        rem_next  = 33'd0;
                        mode_next = bsp_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        rem_next  = len;
                        mode_next = bsp_pkg::MODE_DATA;
                    end
                end
                else
                begin
                    fail      = 1'b1;
                    fail_code = bsp_pkg::ERR_MALFORMED;
                end
            end
            bsp_pkg::MODE_DATA:
            begin
                r0_valid          = 1'b1;
                r0.kind           = bsp_pkg::KIND_PAYLOAD;
                r0.payload_byte   = item.data_byte;
                r0.last_of_string = (rem_reg <= 33'd1);
                if (rem_reg <= 33'd1)
                begin
                    rem_next  = 33'd0;
                    mode_next = bsp_pkg::MODE_IDLE;
                end
                else
                begin
                    rem_next = rem_reg - 33'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (fail)
        begin
            r0_valid      = 1'b1;
            r0            = '0;
            r0.kind       = bsp_pkg::KIND_ERROR;
            r0.error_code = fail_code;
            neg_next      = 1'b0;
            acc_next      = 64'd0;
            seen_next     = 1'b0;
            fz_next       = 1'b0;
            rem_next      = 33'd0;
            mode_next     = bsp_pkg::MODE_HALT;
        end

        r_trunc.kind       = bsp_pkg::KIND_ERROR;
        r_trunc.error_code = bsp_pkg::ERR_TRUNCATED;
        push.count         = r0_valid ? 2'd1 : 2'd0;
        push.first         = r0;
        push.second        = '0;

        if (item.end_of_input)
        begin
            if (mode_next == bsp_pkg::MODE_INT || mode_next == bsp_pkg::MODE_LEN
                || mode_next == bsp_pkg::MODE_DATA)
            begin
                if (r0_valid)
                begin
                    push.count  = 2'd2;
                    push.second = r_trunc;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = r_trunc;
                end
            end
            neg_next  = 1'b0;
            acc_next  = 64'd0;
            seen_next = 1'b0;
            fz_next   = 1'b0;
            rem_next  = 33'd0;
            mode_next = bsp_pkg::MODE_IDLE;
        end

        if (!go)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bsp_pkg::MODE_IDLE;
            neg_reg  <= 1'b0;
            acc_reg  <= 64'd0;
            seen_reg <= 1'b0;
            fz_reg   <= 1'b0;
            rem_reg  <= 33'd0;
        end
        else if (go)
        begin
            mode_reg <= mode_next;
            neg_reg  <= neg_next;
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
            fz_reg   <= fz_next;
            rem_reg  <= rem_next;
        end
    end

`ifndef SYNTHESIS
    a_eoi_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.end_of_input |=> mode_reg == bsp_pkg::MODE_IDLE)
        else $error("end mark did not return parser to idle");
`endif

endmodule

FILE: sv/bsp_result_fifo.sv
// bsp_result_fifo: small result queue taking up to two results a cycle
// depends on bsp_pkg

module bsp_result_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  bsp_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_stall,
    output bsp_pkg::result_t out_result
);

    bsp_pkg::result_t             entries_reg [bsp_pkg::QUEUE_DEPTH];
    logic [bsp_pkg::QUEUE_AW-1:0] head_reg;
    logic [bsp_pkg::QUEUE_AW-1:0] head_next;
    logic [bsp_pkg::QUEUE_AW-1:0] tail_reg;
    logic [bsp_pkg::QUEUE_AW-1:0] tail_next;
    logic [bsp_pkg::QUEUE_CW-1:0] count_reg;
    logic [bsp_pkg::QUEUE_CW-1:0] count_next;
    logic                         pop;

    assign out_valid  = (count_reg != '0);
    assign out_result = entries_reg[head_reg];
    assign pop        = out_valid & ~out_stall;
    assign room       = (count_reg <= bsp_pkg::QUEUE_CW'(bsp_pkg::QUEUE_DEPTH - 2));
    assign head_next  = head_reg + bsp_pkg::QUEUE_AW'(pop);
    assign tail_next  = tail_reg + bsp_pkg::QUEUE_AW'(push.count);
    assign count_next = count_reg + bsp_pkg::QUEUE_CW'(push.count)
                        - bsp_pkg::QUEUE_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entries_reg[tail_reg + bsp_pkg::QUEUE_AW'(1)] <= push.second;
        end
    end

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= bsp_pkg::QUEUE_CW'(bsp_pkg::QUEUE_DEPTH - 2))
        else $error("result pushed without room");
    a_push_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd3)
        else $error("more than two results in one cycle");
    a_push_into_empty_shows: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 && push.count != 2'd0 |=> out_valid)
        else $error("pushed result not presented");
`endif

endmodule

FILE: sv/bencode_scalar_token_parser.sv
// Bencode scalar token parser: integers i<n>e and strings <len>:<bytes>, one byte per request.
// A request is held in the input register, and its result goes to a four-entry result queue.
// An end mark that cuts a token adds a truncation error behind the byte's own result, if it
// has one, so that request can yield two results; the parse stage waits while the queue holds
// more than two. Sustained rate is one byte per cycle while the queue has room, set by the
// combinational multiply-by-ten accumulate of the parse stage. No clearing pass follows reset.

module bencode_scalar_token_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [32:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [63:0] int_value,
    output logic [31:0]        string_length,
    output logic [7:0]         payload_byte,
    output logic               last_of_string,
    output logic [2:0]         error_code
);

    logic [32:0]       max_len_reg;
    bsp_pkg::in_item_t in_item;
    bsp_pkg::in_item_t held_item;
    logic              held_valid;
    logic              room;
    logic              go;
    bsp_pkg::push_t    push;
    bsp_pkg::result_t  result;

    assign in_item.data_byte    = data_byte;
    assign in_item.end_of_input = end_of_input;
    assign go                   = held_valid & room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= bsp_pkg::MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    bsp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (go),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    bsp_parse_core u_parse_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .item    (held_item),
        .max_len (max_len_reg),
        .push    (push)
    );

    bsp_result_fifo u_result_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (result)
    );

    assign kind           = result.kind;
    assign int_value      = result.int_value;
    assign string_length  = result.string_length;
    assign payload_byte   = result.payload_byte;
    assign last_of_string = result.last_of_string;
    assign error_code     = result.error_code;

endmodule
